// ----- rtl/core/ack_fragment_packet_framer_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the ack fragment packet framer
// Shared forms for concurrent checks, clocked by clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ACK_FRAGMENT_PACKET_FRAMER_ASSERT_SVH
`define ACK_FRAGMENT_PACKET_FRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFPF_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("framer check failed");

// The consequent must hold in the cycle after the antecedent.
`define AFPF_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("framer check failed");

`endif

// ----- rtl/core/afpf_pkg.sv -----
// ---------------------------------------------------------------------------
// Ack fragment packet framer package
// Item types, item kind codes and register constants.
// ---------------------------------------------------------------------------
`default_nettype none

package afpf_pkg;

   localparam logic [2:0] FUNC_BEGIN     = 3'd0;
   localparam logic [2:0] FUNC_COMPLETE  = 3'd1;
   localparam logic [2:0] FUNC_PARTIAL   = 3'd2;
   localparam logic [2:0] FUNC_FRAG_HDR  = 3'd3;
   localparam logic [2:0] FUNC_FRAG_DATA = 3'd4;

   localparam int          CSR_ADDR_W      = 3;
   localparam logic        REG_DATA_TYPE   = 1'b0;
   localparam logic [3:0]  DATA_TYPE_RESET = 4'd6;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] word;
      logic        want_reply;
      logic [7:0]  count_complete;
      logic [7:0]  count_partial;
      logic [7:0]  count_fragments;
      logic [5:0]  bit_count;
      logic [62:0] ack_bits;
      logic [6:0]  fragment_number;
      logic        fragment_final;
      logic [13:0] fragment_length;
      logic [7:0]  payload_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       packet_end;
      logic       order_error;
   } rsp_payload_type;

   typedef struct packed {
      logic err;
      logic pkt_end;
   } job_flags_type;

endpackage

`default_nettype wire

// ----- rtl/core/afpf_if.sv -----
// ---------------------------------------------------------------------------
// Framer channel interfaces
// Valid/ready channels for the input items and the result bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface afpf_req_if;
   logic                      valid;
   logic                      ready;
   afpf_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface afpf_rsp_if;
   logic                      valid;
   logic                      ready;
   afpf_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ack_fragment_packet_framer.sv -----
// An item's first byte passes a queue entry, the job register and the output register.
// Throughput: one byte per cycle while rsp_bus is ready, set by the single-byte output
// serializer; an item emits 1 to max(7, 5 + ceil(MAX_ACK_BITS / 7)) bytes.
// A two-entry job queue lets up to two further items be taken while bytes drain.
// Reset is synchronous: phase and counters clear, data_type_code returns to 6.
// ---------------------------------------------------------------------------
// Ack fragment packet framer
// Frames begin, ack and fragment items into the byte stream of a data packet.
// ---------------------------------------------------------------------------
`default_nettype none

module ack_fragment_packet_framer #(
   parameter int MAX_ACK_BITS = 63
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   afpf_req_if.sink                             req_bus,
   afpf_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [afpf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int GROUPS    = (MAX_ACK_BITS + 6) / 7;
   localparam int JOB_BYTES = (5 + GROUPS > 7) ? 5 + GROUPS : 7;
   localparam int CNT_W     = $clog2(JOB_BYTES + 1);
   localparam int FLAG_W    = $bits(afpf_pkg::job_flags_type);
   localparam int QUEUE_W   = JOB_BYTES * 8 + CNT_W + FLAG_W;

   logic [3:0]                data_type_code_ff;
   logic                      front_valid;
   logic                      front_ready;
   logic [JOB_BYTES-1:0][7:0] front_bytes;
   logic [CNT_W-1:0]          front_count;
   afpf_pkg::job_flags_type   front_flags;
   logic                      back_valid;
   logic                      back_ready;
   logic [JOB_BYTES-1:0][7:0] back_bytes;
   logic [CNT_W-1:0]          back_count;
   afpf_pkg::job_flags_type   back_flags;
   logic [QUEUE_W-1:0]        push_data;
   logic [QUEUE_W-1:0]        pop_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == afpf_pkg::REG_DATA_TYPE) ?
                       {28'h0000000, data_type_code_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_type_code_ff <= afpf_pkg::DATA_TYPE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == afpf_pkg::REG_DATA_TYPE) begin
         data_type_code_ff <= csr_pwdata[3:0];
      end
   end

   afpf_front #(
      .MAX_ACK_BITS (MAX_ACK_BITS),
      .JOB_BYTES    (JOB_BYTES),
      .CNT_W        (CNT_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .data_type_code (data_type_code_ff),
      .job_valid      (front_valid),
      .job_ready      (front_ready),
      .job_bytes      (front_bytes),
      .job_count      (front_count),
      .job_flags      (front_flags)
   );

   assign push_data = {front_flags, front_count, front_bytes};
   assign {back_flags, back_count, back_bytes} = pop_data;

   afpf_queue #(
      .WIDTH (QUEUE_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (push_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (pop_data)
   );

   afpf_back #(
      .JOB_BYTES (JOB_BYTES),
      .CNT_W     (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_bytes (back_bytes),
      .job_count (back_count),
      .job_flags (back_flags),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- rtl/core/afpf_queue.sv -----
// ---------------------------------------------------------------------------
// Framer job queue
// Two-entry queue that decouples item classification from byte output.
// ---------------------------------------------------------------------------
`default_nettype none

module afpf_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/afpf_front.sv -----
// ---------------------------------------------------------------------------
// Framer front end
// Checks each item against the packet phase, keeps the section counters and
// builds the list of bytes that the item emits.
// ---------------------------------------------------------------------------
`default_nettype none

module afpf_front #(
   parameter int MAX_ACK_BITS = 63,
   parameter int JOB_BYTES    = 14,
   parameter int CNT_W        = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   afpf_req_if.sink                     req_bus,
   input  wire logic [3:0]              data_type_code,
   output logic                         job_valid,
   input  wire logic                    job_ready,
   output logic [JOB_BYTES-1:0][7:0]    job_bytes,
   output logic [CNT_W-1:0]             job_count,
   output afpf_pkg::job_flags_type      job_flags
);

   localparam int GROUPS  = (MAX_ACK_BITS + 6) / 7;
   localparam int GROUP_W = $clog2(GROUPS + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_COMPLETE,
      PH_PARTIAL,
      PH_FRAG_HDR,
      PH_FRAG_DATA
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [7:0]                complete_left_ff, complete_left_in;
   logic [7:0]                partial_left_ff, partial_left_in;
   logic [7:0]                fragments_left_ff, fragments_left_in;
   logic [7:0]                partial_total_ff, partial_total_in;
   logic [7:0]                fragment_total_ff, fragment_total_in;
   logic [13:0]               payload_left_ff, payload_left_in;

   afpf_pkg::req_payload_type item;
   logic                      accept;
   logic [5:0]                nbits;
   logic [GROUP_W-1:0]        steps;
   logic [GROUPS-1:0][7:0]    grp;
   logic                      section_done;

   assign item          = req_bus.payload;
   assign req_bus.ready = job_ready;
   assign job_valid     = req_bus.valid;
   assign accept        = req_bus.valid && job_ready;

   always_comb begin
      int k;
      k     = 0;
      nbits = (item.bit_count > 6'(MAX_ACK_BITS)) ? 6'(MAX_ACK_BITS) : item.bit_count;
      steps = '0;
      grp   = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (nbits > 6'(7 * g)) begin
            steps = GROUP_W'(g + 1);
         end
         grp[g][7] = (nbits > 6'(7 * (g + 1)));
         for (int t = 0; t < 7; t++) begin
            k = 7 * g + t;
            grp[g][6 - t] = (nbits > 6'(k)) && item.ack_bits[k];
         end
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      complete_left_in  = complete_left_ff;
      partial_left_in   = partial_left_ff;
      fragments_left_in = fragments_left_ff;
      partial_total_in  = partial_total_ff;
      fragment_total_in = fragment_total_ff;
      payload_left_in   = payload_left_ff;
      job_bytes         = '0;
      job_count         = CNT_W'(1);
      job_flags         = '0;
      section_done      = 1'b0;

      priority if (item.func == afpf_pkg::FUNC_BEGIN && phase_ff == PH_IDLE) begin
         complete_left_in  = item.count_complete;
         partial_left_in   = item.count_partial;
         partial_total_in  = item.count_partial;
         fragments_left_in = item.count_fragments;
         fragment_total_in = item.count_fragments;
         payload_left_in   = '0;
         job_bytes[0] = {data_type_code, 4'h0};
         job_bytes[1] = item.word[31:24];
         job_bytes[2] = item.word[23:16];
         job_bytes[3] = item.word[15:8];
         job_bytes[4] = item.word[7:0];
         job_bytes[5] = {item.count_complete != 8'd0, item.count_partial != 8'd0, 3'b000,
                         item.want_reply, 2'b00};
         job_count = CNT_W'(7);
         if (item.count_complete != 8'd0) begin
            job_bytes[6] = item.count_complete;
            phase_in     = PH_COMPLETE;
         end else if (item.count_partial != 8'd0) begin
            job_bytes[6] = item.count_partial;
            phase_in     = PH_PARTIAL;
         end else begin
            job_bytes[6] = item.count_fragments;
            if (item.count_fragments == 8'd0) begin
               job_flags.pkt_end = 1'b1;
               phase_in          = PH_IDLE;
            end else begin
               phase_in = PH_FRAG_HDR;
            end
         end
      end else if (item.func == afpf_pkg::FUNC_COMPLETE && phase_ff == PH_COMPLETE) begin
         job_bytes[0]     = item.word[31:24];
         job_bytes[1]     = item.word[23:16];
         job_bytes[2]     = item.word[15:8];
         job_bytes[3]     = item.word[7:0];
         job_count        = CNT_W'(4);
         complete_left_in = complete_left_ff - 8'd1;
         if (complete_left_ff == 8'd1) begin
            job_count = CNT_W'(5);
            if (partial_left_ff != 8'd0) begin
               job_bytes[4] = partial_total_ff;
               phase_in     = PH_PARTIAL;
            end else begin
               job_bytes[4] = fragment_total_ff;
               if (fragments_left_ff == 8'd0) begin
                  job_flags.pkt_end = 1'b1;
                  phase_in          = PH_IDLE;
               end else begin
                  phase_in = PH_FRAG_HDR;
               end
            end
         end
      end else if (item.func == afpf_pkg::FUNC_PARTIAL && phase_ff == PH_PARTIAL) begin
         section_done    = (partial_left_ff == 8'd1);
         partial_left_in = partial_left_ff - 8'd1;
         job_bytes[0]    = item.word[31:24];
         job_bytes[1]    = item.word[23:16];
         job_bytes[2]    = item.word[15:8];
         job_bytes[3]    = item.word[7:0];
         for (int j = 0; j < GROUPS; j++) begin
            if (GROUP_W'(j) < steps) begin
               job_bytes[4 + j] = grp[j];
            end
         end
         for (int j = 0; j <= GROUPS; j++) begin
            if (section_done && GROUP_W'(j) == steps) begin
               job_bytes[4 + j] = fragment_total_ff;
            end
         end
         job_count = CNT_W'(4) + CNT_W'(steps) + CNT_W'(section_done);
         if (section_done) begin
            if (fragments_left_ff == 8'd0) begin
               job_flags.pkt_end = 1'b1;
               phase_in          = PH_IDLE;
            end else begin
               phase_in = PH_FRAG_HDR;
            end
         end
      end else if (item.func == afpf_pkg::FUNC_FRAG_HDR && phase_ff == PH_FRAG_HDR) begin
         job_bytes[0]      = item.word[31:24];
         job_bytes[1]      = item.word[23:16];
         job_bytes[2]      = item.word[15:8];
         job_bytes[3]      = item.word[7:0];
         job_bytes[4]      = {item.fragment_number, item.fragment_final};
         job_bytes[5]      = {2'b00, item.fragment_length[13:8]};
         job_bytes[6]      = item.fragment_length[7:0];
         job_count         = CNT_W'(7);
         fragments_left_in = fragments_left_ff - 8'd1;
         payload_left_in   = item.fragment_length;
         if (item.fragment_length != 14'd0) begin
            phase_in = PH_FRAG_DATA;
         end else if (fragments_left_ff == 8'd1) begin
            job_flags.pkt_end = 1'b1;
            phase_in          = PH_IDLE;
         end else begin
            phase_in = PH_FRAG_HDR;
         end
      end else if (item.func == afpf_pkg::FUNC_FRAG_DATA && phase_ff == PH_FRAG_DATA) begin
         job_bytes[0]    = item.payload_byte;
         payload_left_in = payload_left_ff - 14'd1;
         if (payload_left_ff == 14'd1) begin
            if (fragments_left_ff == 8'd0) begin
               job_flags.pkt_end = 1'b1;
               phase_in          = PH_IDLE;
            end else begin
               phase_in = PH_FRAG_HDR;
            end
         end
      end else begin
         job_flags.err = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         complete_left_ff  <= '0;
         partial_left_ff   <= '0;
         fragments_left_ff <= '0;
         partial_total_ff  <= '0;
         fragment_total_ff <= '0;
         payload_left_ff   <= '0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         complete_left_ff  <= complete_left_in;
         partial_left_ff   <= partial_left_in;
         fragments_left_ff <= fragments_left_in;
         partial_total_ff  <= partial_total_in;
         fragment_total_ff <= fragment_total_in;
         payload_left_ff   <= payload_left_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/afpf_back.sv -----
// ---------------------------------------------------------------------------
// Framer back end
// Sends the bytes of each job one per cycle, while rsp_bus is ready, through a registered output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ack_fragment_packet_framer_assert.svh"

module afpf_back #(
   parameter int JOB_BYTES = 14,
   parameter int CNT_W     = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      job_valid,
   output logic                           job_ready,
   input  wire logic [JOB_BYTES-1:0][7:0] job_bytes,
   input  wire logic [CNT_W-1:0]          job_count,
   input  wire afpf_pkg::job_flags_type   job_flags,
   afpf_rsp_if.source                     rsp_bus
);

   logic [JOB_BYTES-1:0][7:0]  cur_bytes_ff;
   logic [CNT_W-1:0]           left_ff;
   afpf_pkg::job_flags_type    cur_flags_ff;
   logic                       out_valid_ff;
   afpf_pkg::rsp_payload_type  out_payload_ff;
   logic                       advance;
   logic                       busy;
   logic                       last;
   logic                       emit;
   logic                       load;

   assign advance   = !out_valid_ff || rsp_bus.ready;
   assign busy      = (left_ff != '0);
   assign last      = (left_ff == CNT_W'(1));
   assign emit      = advance && busy;
   assign load      = !busy || (emit && last);
   assign job_ready = load;

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= busy;
         end
         if (job_valid && load) begin
            left_ff <= job_count;
         end else if (emit) begin
            left_ff <= left_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_payload_ff.out_byte    <= cur_bytes_ff[0];
         out_payload_ff.run_last    <= last;
         out_payload_ff.packet_end  <= last && cur_flags_ff.pkt_end;
         out_payload_ff.order_error <= cur_flags_ff.err;
      end
      if (job_valid && load) begin
         cur_bytes_ff <= job_bytes;
         cur_flags_ff <= job_flags;
      end else if (emit) begin
         cur_bytes_ff <= {8'h00, cur_bytes_ff[JOB_BYTES-1:1]};
      end
   end

   `AFPF_IMPLIES(a_err_single, out_valid_ff && out_payload_ff.order_error, out_payload_ff.run_last && !out_payload_ff.packet_end)
   `AFPF_IMPLIES(a_end_is_last, out_valid_ff && out_payload_ff.packet_end, out_payload_ff.run_last)
   `AFPF_NEXT(a_emit_fills_output, emit, out_valid_ff)
   `AFPF_IMPLIES(a_job_nonempty, job_valid && job_ready, job_count != '0)

endmodule

`default_nettype wire

// ----- tb/tb_ack_fragment_packet_framer.sv -----
// ---------------------------------------------------------------------------
// Ack fragment packet framer testbench
// Drives begin, ack and fragment items into the framer and predicts every
// packet byte, including the error byte for items that arrive out of order.
// Each result is checked in order against the predicted byte stream. Both
// sides of the stream insert random gaps, and the data type register is
// rewritten between runs.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_ack_fragment_packet_framer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ACK_BITS = 63;
   localparam int ADDR_W = afpf_pkg::CSR_ADDR_W;
   localparam logic [ADDR_W-1:0] DATA_TYPE_ADDR = ADDR_W'(4 * afpf_pkg::REG_DATA_TYPE);
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_COMPLETE  = 3'd1,
      PH_PARTIAL   = 3'd2,
      PH_FRAG_HDR  = 3'd3,
      PH_FRAG_DATA = 3'd4
   } framer_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   afpf_req_if req_bus ();
   afpf_rsp_if rsp_bus ();

   ack_fragment_packet_framer #(
      .MAX_ACK_BITS(MAX_ACK_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   framer_phase_type pkt_phase = PH_IDLE;
   logic [3:0]       type_code = afpf_pkg::DATA_TYPE_RESET;
   logic [7:0]       complete_left = '0;
   logic [7:0]       partial_left = '0;
   logic [7:0]       fragments_left = '0;
   logic [7:0]       partial_total = '0;
   logic [7:0]       fragment_total = '0;
   logic [13:0]      payload_left = '0;

   afpf_pkg::rsp_payload_type expected_bytes[$];
   int unsigned      fail_count = 0;
   bit               req_idle = 1'b1;
   bit               rsp_idle = 1'b1;
   int unsigned      rsp_hold_req = 0;
   int unsigned      rsp_stall_left = 0;

   always #4ns clock = ~clock;

   function automatic int pick_gap(input bit enable);
      int r;
      r = $urandom_range(0, 99);
      if (!enable || r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      afpf_pkg::rsp_payload_type r;
      r = '0;
      r.out_byte = b;
      expected_bytes.push_back(r);
   endfunction

   function automatic void put_word(input logic [31:0] w);
      put_byte(w[31:24]);
      put_byte(w[23:16]);
      put_byte(w[15:8]);
      put_byte(w[7:0]);
   endfunction

   function automatic logic open_fragment_section();
      put_byte(fragment_total);
      if (fragments_left == 0) begin
         pkt_phase = PH_IDLE;
         return 1'b1;
      end
      pkt_phase = PH_FRAG_HDR;
      return 1'b0;
   endfunction

   function automatic logic close_fragment();
      if (fragments_left == 0) begin
         pkt_phase = PH_IDLE;
         return 1'b1;
      end
      pkt_phase = PH_FRAG_HDR;
      return 1'b0;
   endfunction

   // Appends the bytes that one accepted item produces and advances the packet state.
   function automatic void frame_item(input afpf_pkg::req_payload_type it);
      afpf_pkg::rsp_payload_type last;
      logic [7:0]      flag;
      logic [7:0]      grp;
      logic            pkt_end;
      logic            bad;
      int              nbits;
      int              steps;
      int              k;
      pkt_end = 1'b0;
      bad = 1'b0;
      if (it.func == afpf_pkg::FUNC_BEGIN && pkt_phase == PH_IDLE) begin
         flag = 8'h00;
         flag[2] = it.want_reply;
         flag[7] = (it.count_complete != 0);
         flag[6] = (it.count_partial != 0);
         complete_left = it.count_complete;
         partial_left = it.count_partial;
         partial_total = it.count_partial;
         fragments_left = it.count_fragments;
         fragment_total = it.count_fragments;
         payload_left = '0;
         put_byte({type_code, 4'h0});
         put_word(it.word);
         put_byte(flag);
         if (it.count_complete != 0) begin
            put_byte(it.count_complete);
            pkt_phase = PH_COMPLETE;
         end else if (it.count_partial != 0) begin
            put_byte(it.count_partial);
            pkt_phase = PH_PARTIAL;
         end else begin
            pkt_end = open_fragment_section();
         end
      end else if (it.func == afpf_pkg::FUNC_COMPLETE && pkt_phase == PH_COMPLETE) begin
         put_word(it.word);
         complete_left = complete_left - 8'd1;
         if (complete_left == 0) begin
            if (partial_left != 0) begin
               put_byte(partial_total);
               pkt_phase = PH_PARTIAL;
            end else begin
               pkt_end = open_fragment_section();
            end
         end
      end else if (it.func == afpf_pkg::FUNC_PARTIAL && pkt_phase == PH_PARTIAL) begin
         nbits = it.bit_count;
         if (nbits > MAX_ACK_BITS) begin
            nbits = MAX_ACK_BITS;
         end
         steps = (nbits + 6) / 7;
         put_word(it.word);
         for (int i = 0; i < steps; i++) begin
            grp = (i + 1 < steps) ? 8'h80 : 8'h00;
            for (int t = 0; t < 7; t++) begin
               k = i * 7 + t;
               if (k < nbits && it.ack_bits[k]) begin
                  grp[6 - t] = 1'b1;
               end
            end
            put_byte(grp);
         end
         partial_left = partial_left - 8'd1;
         if (partial_left == 0) begin
            pkt_end = open_fragment_section();
         end
      end else if (it.func == afpf_pkg::FUNC_FRAG_HDR && pkt_phase == PH_FRAG_HDR) begin
         put_word(it.word);
         put_byte({it.fragment_number, it.fragment_final});
         put_byte({2'b00, it.fragment_length[13:8]});
         put_byte(it.fragment_length[7:0]);
         fragments_left = fragments_left - 8'd1;
         payload_left = it.fragment_length;
         if (it.fragment_length != 0) begin
            pkt_phase = PH_FRAG_DATA;
         end else begin
            pkt_end = close_fragment();
         end
      end else if (it.func == afpf_pkg::FUNC_FRAG_DATA && pkt_phase == PH_FRAG_DATA) begin
         put_byte(it.payload_byte);
         payload_left = payload_left - 14'd1;
         if (payload_left == 0) begin
            pkt_end = close_fragment();
         end
      end else begin
         bad = 1'b1;
         put_byte(8'h00);
      end
      last = expected_bytes.pop_back();
      last.run_last = 1'b1;
      last.packet_end = pkt_end;
      last.order_error = bad;
      expected_bytes.push_back(last);
   endfunction

   function automatic logic [7:0] small_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         return 8'd0;
      end
      if (r < 95) begin
         return 8'($urandom_range(1, 3));
      end
      return 8'($urandom_range(4, 12));
   endfunction

   function automatic afpf_pkg::req_payload_type random_item(input logic [2:0] func);
      afpf_pkg::req_payload_type it;
      int r;
      it.func = func;
      it.word = $urandom();
      it.want_reply = 1'($urandom());
      it.count_complete = small_count();
      it.count_partial = small_count();
      it.count_fragments = small_count();
      it.bit_count = 6'($urandom());
      it.ack_bits = 63'({$urandom(), $urandom()});
      it.fragment_number = 7'($urandom());
      it.fragment_final = 1'($urandom());
      r = $urandom_range(0, 99);
      if (r < 70) begin
         it.fragment_length = 14'($urandom_range(0, 4));
      end else if (r < 95) begin
         it.fragment_length = 14'($urandom_range(5, 20));
      end else begin
         it.fragment_length = 14'($urandom_range(21, 63));
      end
      it.payload_byte = 8'($urandom());
      return it;
   endfunction

   function automatic afpf_pkg::req_payload_type legal_item();
      case (pkt_phase)
         PH_IDLE:      return random_item(afpf_pkg::FUNC_BEGIN);
         PH_COMPLETE:  return random_item(afpf_pkg::FUNC_COMPLETE);
         PH_PARTIAL:   return random_item(afpf_pkg::FUNC_PARTIAL);
         PH_FRAG_HDR:  return random_item(afpf_pkg::FUNC_FRAG_HDR);
         default:      return random_item(afpf_pkg::FUNC_FRAG_DATA);
      endcase
   endfunction

   task automatic send_item(input afpf_pkg::req_payload_type it);
      int gap;
      gap = pick_gap(req_idle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= it;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      frame_item(it);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic access_data_type(input logic wr, input logic [3:0] code);
      logic [31:0] data;
      data = $urandom();
      data[3:0] = code;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= DATA_TYPE_ADDR;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (wr) begin
         type_code = code;
      end else if (csr_prdata[3:0] !== type_code) begin
         $error("data_type_code: expected %0d, got %0d", type_code, csr_prdata[3:0]);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_data_type(input logic [3:0] code);
      access_data_type(1'b1, code);
      access_data_type(1'b0, code);
   endtask

   task automatic finish_packet();
      while (pkt_phase != PH_IDLE) begin
         send_item(legal_item());
      end
   endtask

   task automatic test_register_reset();
      access_data_type(1'b0, afpf_pkg::DATA_TYPE_RESET);
   endtask

   task automatic test_directed_sequence();
      afpf_pkg::req_payload_type it;
      send_item(random_item(FUNC_UNUSED_HI));
      send_item(random_item(FUNC_UNUSED_LO));
      send_item(random_item(afpf_pkg::FUNC_FRAG_DATA));
      it = random_item(afpf_pkg::FUNC_BEGIN);
      it.word = 32'hFFFF_FFFF;
      it.want_reply = 1'b1;
      it.count_complete = 8'd0;
      it.count_partial = 8'd0;
      it.count_fragments = 8'd0;
      send_item(it);
      it = random_item(afpf_pkg::FUNC_BEGIN);
      it.word = 32'h0000_0000;
      it.want_reply = 1'b0;
      it.count_complete = 8'd2;
      it.count_partial = 8'd4;
      it.count_fragments = 8'd3;
      send_item(it);
      send_item(random_item(afpf_pkg::FUNC_PARTIAL));
      send_item(random_item(afpf_pkg::FUNC_BEGIN));
      it = random_item(afpf_pkg::FUNC_COMPLETE);
      it.word = 32'hFFFF_FFFF;
      send_item(it);
      it.word = 32'h0000_0000;
      send_item(it);
      it = random_item(afpf_pkg::FUNC_PARTIAL);
      it.bit_count = 6'd0;
      send_item(it);
      it.word = 32'h1234_5678;
      it.bit_count = 6'd63;
      it.ack_bits = '1;
      send_item(it);
      it.bit_count = 6'd7;
      send_item(it);
      it.bit_count = 6'd8;
      it.ack_bits = {31'h5555_5555, 32'h5555_5555};
      send_item(it);
      it = random_item(afpf_pkg::FUNC_FRAG_HDR);
      it.fragment_number = 7'd127;
      it.fragment_final = 1'b1;
      it.fragment_length = 14'd0;
      send_item(it);
      send_item(random_item(afpf_pkg::FUNC_FRAG_DATA));
      it.fragment_number = 7'd0;
      it.fragment_final = 1'b0;
      it.fragment_length = 14'd2;
      send_item(it);
      it = random_item(afpf_pkg::FUNC_FRAG_DATA);
      it.payload_byte = 8'hFF;
      send_item(it);
      it.payload_byte = 8'h00;
      send_item(it);
      it = random_item(afpf_pkg::FUNC_FRAG_HDR);
      it.fragment_length = 14'd1;
      send_item(it);
      send_item(random_item(afpf_pkg::FUNC_FRAG_HDR));
      it = random_item(afpf_pkg::FUNC_FRAG_DATA);
      it.payload_byte = 8'hA5;
      send_item(it);
      wait_idle();
   endtask

   task automatic test_random_packets(input int count, input logic [3:0] code,
                                      input bit sender_gaps, input bit receiver_gaps);
      int n;
      set_data_type(code);
      req_idle = sender_gaps;
      rsp_idle = receiver_gaps;
      n = 0;
      while (n < count || pkt_phase != PH_IDLE) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(random_item(3'($urandom_range(0, 7))));
         end else begin
            send_item(legal_item());
         end
         n++;
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_data_type(4'($urandom()));
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      rsp_hold_req = 250;
      repeat (24) send_item(legal_item());
      finish_packet();
      wait_idle();
   endtask

   task automatic test_large_counts();
      afpf_pkg::req_payload_type it;
      set_data_type(4'($urandom()));
      req_idle = 1'b0;
      rsp_idle = 1'b1;
      it = random_item(afpf_pkg::FUNC_BEGIN);
      it.count_complete = 8'd16;
      it.count_partial = 8'd8;
      it.count_fragments = 8'd1;
      send_item(it);
      finish_packet();
      wait_idle();
   endtask

   task automatic test_long_fragment();
      afpf_pkg::req_payload_type it;
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      it = random_item(afpf_pkg::FUNC_BEGIN);
      it.count_complete = 8'd0;
      it.count_partial = 8'd0;
      it.count_fragments = 8'd1;
      send_item(it);
      it = random_item(afpf_pkg::FUNC_FRAG_HDR);
      it.fragment_length = 14'd257;
      send_item(it);
      finish_packet();
      wait_idle();
   endtask

   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_hold_req != 0) begin
            rsp_stall_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (rsp_stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            gap = pick_gap(rsp_idle);
            if (gap != 0) begin
               rsp_bus.ready <= 1'b0;
               rsp_stall_left = gap - 1;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      afpf_pkg::rsp_payload_type want;
      afpf_pkg::rsp_payload_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %0h order_error %0b",
                   got.out_byte, got.order_error);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
               fail_count++;
            end
            if (got.run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
               fail_count++;
            end
            if (got.packet_end !== want.packet_end) begin
               $error("packet_end: expected %0b, got %0b", want.packet_end, got.packet_end);
               fail_count++;
            end
            if (got.order_error !== want.order_error) begin
               $error("order_error: expected %0b, got %0b", want.order_error,
                      got.order_error);
               fail_count++;
            end
         end
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_directed_sequence();
      test_random_packets(35, 4'hF, 1'b1, 1'b1);
      test_random_packets(25, 4'h0, 1'b0, 1'b0);
      test_backpressure();
      test_large_counts();
      test_long_fragment();
      test_random_packets(20, 4'($urandom()), 1'b1, 1'b0);
      test_random_packets(20, 4'($urandom()), 1'b0, 1'b1);
      wait_idle();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/afpf_pkg.sv
rtl/core/afpf_if.sv
rtl/core/afpf_queue.sv
rtl/core/afpf_front.sv
rtl/core/afpf_back.sv
rtl/core/ack_fragment_packet_framer.sv
tb/tb_ack_fragment_packet_framer.sv
